[design/ssort_pkg.sv]
// shared types and helpers for the selection sorter
// no dependencies; imported by the channel interfaces, the cell and the top level

package ssort_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic load;   // insert the new value into the sorted row
    logic shift;  // move the row one place toward cell 0
  } cell_ctl_t;

  // signed ascending order
  function automatic logic key_less(input value_t a, input value_t b);
    return a < b;
  endfunction

endpackage

[design/ssort_if.sv]
// valid/ready channels of the selection sorter, input and result side
// depends on ssort_pkg

interface ssort_in_if import ssort_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ssort_out_if import ssort_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   last_out;
  logic   overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

[design/ssort_cell.sv]
// one cell of the insertion row: holds a single value of the sorted run
// depends on ssort_pkg

module ssort_cell import ssort_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  value_t    new_value,
  input  logic      occ,
  input  logic      prev_disp,
  input  value_t    prev_value,
  input  value_t    next_value,
  output value_t    value_o,
  output logic      disp_o
);

  value_t value_r;

  // new value goes in front of this one, so this one moves right
  assign disp_o  = occ && key_less(new_value, value_r);
  assign value_o = value_r;

  // when neither load nor shift is set the cell holds its value
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (prev_disp) begin
        value_r <= prev_value;
      end else if (disp_o || !occ) begin
        value_r <= new_value;
      end
    end else if (ctl.shift) begin
      value_r <= next_value;
    end
  end

endmodule

[design/selection_sorter.sv]
// selection_sorter: top level, a row of ssort_cell insertion cells plus load/drain control
// depends on ssort_pkg, ssort_if (ssort_in_if, ssort_out_if) and ssort_cell
//
// The block sorts a run of signed 32-bit values into ascending order. Each input
// beat is inserted into a row of DEPTH cells in the cycle it is accepted, so input
// beats are taken one per cycle while the run loads; the row stays sorted at all
// times. Beats beyond DEPTH are dropped and every result of that run shows overflow.
// The beat with last set ends the run: from the next cycle the row drains through
// cell 0, one result beat per cycle while out ready is high, last_out on the final
// one. No input is taken while a run drains; input is taken again in the cycle
// after the final result beat. Equal values are all kept.

module selection_sorter import ssort_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  ssort_in_if.sink          in_ch,
  ssort_out_if.source       out_ch
);

  localparam int COUNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t              state_r;
  logic [COUNT_W-1:0]  fill_count_r;
  logic                dropped_r;

  logic      in_acc;
  logic      out_acc;
  logic      full;
  cell_ctl_t ctl;

  // value and displacement chains along the row
  value_t     val_chain  [DEPTH+1:0];
  logic       disp_chain [DEPTH:0];
  logic [DEPTH-1:0] occ;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign full    = (fill_count_r == COUNT_W'(DEPTH));

  // insert only while there is room, shift on each result beat taken
  assign ctl.load  = in_acc && !full;
  assign ctl.shift = out_acc;

  assign in_ch.ready = (state_r == ST_LOAD);

  // cell 0 is the head of the row and feeds the result channel directly
  assign out_ch.valid        = (state_r == ST_DRAIN);
  assign out_ch.sorted_value = val_chain[1];
  assign out_ch.last_out     = (fill_count_r == COUNT_W'(1));
  assign out_ch.overflow     = dropped_r;

  // chain ends: nothing displaces into cell 0, the tail cell shifts in its own value
  assign disp_chain[0]     = 1'b0;
  assign val_chain[0]      = '0;
  assign val_chain[DEPTH+1] = val_chain[DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    // a cell holds a live value when it sits below the fill count
    assign occ[g] = (COUNT_W'(g) < fill_count_r);

    ssort_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_value  (in_ch.value),
      .occ        (occ[g]),
      .prev_disp  (disp_chain[g]),
      .prev_value (val_chain[g]),
      .next_value (val_chain[g+2]),
      .value_o    (val_chain[g+1]),
      .disp_o     (disp_chain[g+1])
    );
  end

  // run control: fill count, drop flag and load/drain state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      fill_count_r <= '0;
      dropped_r    <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (full) begin
              dropped_r <= 1'b1;
            end else begin
              fill_count_r <= fill_count_r + COUNT_W'(1);
            end
            if (in_ch.last) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_acc) begin
            fill_count_r <= fill_count_r - COUNT_W'(1);
            if (fill_count_r == COUNT_W'(1)) begin
              // final beat of the run: clear for the next one
              dropped_r <= 1'b0;
              state_r   <= ST_LOAD;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  // a drain never starts or runs on an empty row
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (fill_count_r != '0))
    else $error("drain with empty row");

  // fill count never passes the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= COUNT_W'(DEPTH))
    else $error("fill count beyond depth");

  // last input beat always starts a drain
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last) |=> (out_ch.valid && !in_ch.ready))
    else $error("last beat did not start drain");

  // overflow stays fixed across one drain
  a_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && $past(out_ch.valid)) |-> $stable(out_ch.overflow))
    else $error("overflow changed during drain");

  // head of the row is never above its neighbor while draining
  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && fill_count_r > COUNT_W'(1)) |-> !key_less(val_chain[2], val_chain[1]))
    else $error("row out of order");

endmodule

[dv/ssort_checker.sv]
// result checker for the selection sorter: watches both channels, predicts, compares
// depends on ssort_pkg and the channel interfaces in ssort_if
`timescale 1ns / 1ps

module ssort_checker import ssort_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  ssort_in_if   in_mon,
  ssort_out_if  out_mon,
  output int    fail_count,
  output int    open_count,
  output int    checked_count
);

  typedef struct packed {
    value_t value;
    logic   last;
    logic   ovf;
  } sorted_beat_t;

  value_t       run_row[$];   // values of the current run, kept ascending
  logic         run_dropped;
  sorted_beat_t due_q[$];     // sorted beats still to come out

  // place a new value in ascending signed order
  function automatic void insert_sorted(input value_t v);
    int pos;
    pos = run_row.size();
    for (int i = 0; i < run_row.size(); i++) begin
      if (v < run_row[i]) begin
        pos = i;
        break;
      end
    end
    run_row.insert(pos, v);
  endfunction

  initial begin
    fail_count    = 0;
    open_count    = 0;
    checked_count = 0;
    run_dropped   = 1'b0;
  end

  always @(posedge clk) begin
    sorted_beat_t want;
    if (!rst_n) begin
      run_row.delete();
      due_q.delete();
      run_dropped = 1'b0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (run_row.size() < DEPTH) insert_sorted(in_mon.value);
        else run_dropped = 1'b1;
        if (in_mon.last) begin
          for (int i = 0; i < run_row.size(); i++) begin
            want.value = run_row[i];
            want.last  = (i == run_row.size() - 1);
            want.ovf   = run_dropped;
            due_q.push_back(want);
          end
          run_row.delete();
          run_dropped = 1'b0;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_q.size() == 0) begin
          $error("unexpected result beat: sorted_value %0d", out_mon.sorted_value);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          checked_count++;
          if (out_mon.sorted_value !== want.value) begin
            $error("sorted_value: expected %0d, got %0d", want.value, out_mon.sorted_value);
            fail_count++;
          end
          if (out_mon.last_out !== want.last) begin
            $error("last_out: expected %0b, got %0b", want.last, out_mon.last_out);
            fail_count++;
          end
          if (out_mon.overflow !== want.ovf) begin
            $error("overflow: expected %0b, got %0b", want.ovf, out_mon.overflow);
            fail_count++;
          end
        end
      end
    end
    open_count = due_q.size();
  end

endmodule

[dv/tb_top.sv]
// top of the selection sorter testbench: clock, reset, stimulus, receiver stalls, verdict
// depends on ssort_pkg, ssort_if, selection_sorter and ssort_checker
`timescale 1ns / 1ps

module tb_top import ssort_pkg::*; ();

  localparam int DEPTH       = 64;
  localparam int TARGET_BEATS = 330;

  // receiver stall patterns
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  ssort_in_if  in_ch ();
  ssort_out_if out_ch ();

  int fail_count;
  int open_count;
  int checked_count;

  int beats_sent;
  int runs_sent;
  int ovf_runs;
  int burst_left;

  stall_mode_t stall_mode;
  int          stall_left;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  selection_sorter #(.DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ssort_checker #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .open_count    (open_count),
    .checked_count (checked_count)
  );

  // receiver: switch between stall patterns at random intervals,
  // so stalls land on the first, middle and last beat of a drain
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode   <= STALL_NONE;
      stall_left   <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        stall_left <= $urandom_range(16, 96);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_ch.ready <= 1'b1;
        STALL_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
        STALL_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     out_ch.ready <= ~out_ch.ready;
      endcase
    end
  end

  // value mix: extremes, a narrow band around zero for duplicates, full range
  function automatic value_t pick_value();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(VALUE_W-1){1'b0}}};
      1:       return {1'b0, {(VALUE_W-1){1'b1}}};
      2, 3:    return value_t'($signed($urandom_range(0, 8)) - 4);
      default: return value_t'($urandom);
    endcase
  endfunction

  // drive one beat and hold it until accepted; valid stays high inside a burst
  // and drops only for a nonzero gap between bursts
  task automatic send_beat(input value_t v, input logic is_last);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // one run of random values, last on the final beat
  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_beat(pick_value(), i == len - 1);
    runs_sent++;
    if (len > DEPTH) ovf_runs++;
  endtask

  initial begin
    int len;
    beats_sent = 0;
    runs_sent  = 0;
    ovf_runs   = 0;
    burst_left = 0;

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    in_ch.last   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // run of a single beat, at the top of the range
    send_beat({1'b0, {(VALUE_W-1){1'b1}}}, 1'b1);
    runs_sent++;

    // extremes, zero and +-1, with repeats of both ends
    send_beat({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
    send_beat({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
    send_beat(0, 1'b0);
    send_beat(-1, 1'b0);
    send_beat(1, 1'b0);
    send_beat({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
    send_beat({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
    send_beat(-1, 1'b1);
    runs_sent++;

    // all equal
    for (int i = 0; i < 4; i++) send_beat(7, i == 3);
    runs_sent++;

    // already descending, then already ascending
    for (int i = 0; i < 5; i++) send_beat(100 - 50 * i, i == 4);
    runs_sent++;
    for (int i = 0; i < 5; i++) send_beat(-2 + i, i == 4);
    runs_sent++;

    // store exactly full, then one past full so the last beat itself is dropped
    send_run(DEPTH);
    send_run(DEPTH + 1);

    // random runs: mostly short, now and then long enough to overflow
    while (beats_sent < TARGET_BEATS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 8)
                                        : $urandom_range(1, 12);
      send_run(len);
    end
    in_ch.valid <= 1'b0;

    // let the final drain finish, then keep the clock running to catch stray beats
    do @(posedge clk); while (open_count != 0);
    repeat (2 * DEPTH) @(posedge clk);

    $display("covered %0d runs (%0d with dropped beats), %0d input beats",
             runs_sent, ovf_runs, beats_sent);
    $display("%0d sorted beats checked, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // timeout, far beyond the slowest legal run
  initial begin
    #(200_000 * 12);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[selection_sorter.f]
design/ssort_pkg.sv
design/ssort_if.sv
design/ssort_cell.sv
design/selection_sorter.sv
dv/ssort_checker.sv
dv/tb_top.sv
